FILE: hw/rtl/sed_pkg.sv
// Shared types and constants of the speech endpoint detector.
// Depends on nothing; every other file of the block refers to it by scoped names.
package sed_pkg;

  // Fixed widths of the sample, energy, level, counter, configuration, divider and result fields.
  localparam int SAMPLE_W  = 16;
  localparam int ENERGY_W  = 40;
  localparam int LEVEL_W   = 16;
  localparam int BGSUM_W   = 20;
  localparam int INDEX_W   = 24;
  localparam int FRAMES_W  = 16;
  localparam int RUN_W     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int DIV_NUM_W = 24;
  localparam int DIV_DEN_W = 9;

  // 10*log10(2) in Q16, and the saturated sample index.
  localparam logic [17:0]        DB_PER_LOG2_Q16 = 18'd197283;
  localparam logic [INDEX_W-1:0] INDEX_MAX       = 24'hFFFFFF;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IGNORE_FRAMES    = 3'd0,
    REG_RUN_THRESHOLD    = 3'd1,
    REG_SPEECH_MARGIN_DB = 3'd2,
    REG_ADJUST_RATE      = 3'd3,
    REG_FORGET_FACTOR    = 3'd4
  } reg_idx_t;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_SQ_MUL,
    S_SQ_UPD,
    S_DB_MUL,
    S_DB_FIN,
    S_DISPATCH,
    S_BG_DIV,
    S_SM_START,
    S_SM_DIV,
    S_ADJ_MUL,
    S_ADJ_ADD,
    S_DECIDE,
    S_CHECK,
    S_FINISH
  } state_t;

  // Datapath operations.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_NORM,
    OP_CUR_ZERO,
    OP_SQ_MUL,
    OP_SQ_UPD,
    OP_DB_MUL,
    OP_DB_FIN,
    OP_BG_ADD,
    OP_BG_DIV_START,
    OP_BG_LOAD,
    OP_SM_START,
    OP_SM_LOAD,
    OP_ADJ_MUL,
    OP_ADJ_ADD,
    OP_DECIDE,
    OP_EMIT_FOUND,
    OP_EMIT_NONE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_frame_end;  // the offered item completes a frame that is processed
    logic zero_energy;
    logic norm_done;
    logic sq_last;
    logic skip;
    logic bg_phase;
    logic first_class;
    logic div_done;
    logic onset;
    logic last;
    logic out_valid;
  } dp_status_t;

endpackage

FILE: hw/rtl/sed_ifs.sv
// Handshake interfaces of the speech endpoint detector: samples in, results out,
// configuration writes. Depends on sed_pkg for the field widths.
interface sed_sample_if;
  logic                             valid;
  logic                             ready;
  logic signed [sed_pkg::SAMPLE_W-1:0] sample_value;
  logic                             first_sample;
  logic                             last_sample;
  modport source (output valid, sample_value, first_sample, last_sample, input ready);
  modport sink (input valid, sample_value, first_sample, last_sample, output ready);
endinterface

interface sed_onset_if;
  logic                          valid;
  logic                          ready;
  logic                          onset_found;
  logic [sed_pkg::INDEX_W-1:0]   onset_offset;
  modport source (output valid, onset_found, onset_offset, input ready);
  modport sink (input valid, onset_found, onset_offset, output ready);
endinterface

interface sed_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sed_pkg::CFG_IDX_W-1:0]   index;
  logic [sed_pkg::CFG_DAT_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/sed_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the background
// average and the level smoothing. Depends on sed_pkg for widths.
module sed_divider (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sed_pkg::DIV_NUM_W-1:0]    num,
  input  logic [sed_pkg::DIV_DEN_W-1:0]    den,
  output logic [sed_pkg::DIV_NUM_W-1:0]    quo,
  output logic                             done
);

  localparam int CNT_W = $clog2(sed_pkg::DIV_NUM_W);

  logic [sed_pkg::DIV_DEN_W-1:0] rem;
  logic [sed_pkg::DIV_DEN_W-1:0] dvs;
  logic [sed_pkg::DIV_NUM_W-1:0] q;
  logic [CNT_W-1:0]              cnt;
  logic                          busy;
  logic [sed_pkg::DIV_DEN_W:0]   trial;
  logic                          fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {rem, q[sed_pkg::DIV_NUM_W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // Step sequencing: the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
      q    <= num;
      dvs  <= den;
    end else if (busy) begin
      if (fits) begin
        rem <= sed_pkg::DIV_DEN_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[sed_pkg::DIV_DEN_W-1:0];
      end
      q <= {q[sed_pkg::DIV_NUM_W-2:0], fits};
      if (cnt == CNT_W'(sed_pkg::DIV_NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      cnt <= cnt + 1'b1;
    end
  end

  assign quo = q;

endmodule

FILE: hw/rtl/sed_datapath.sv
// Datapath of the speech endpoint detector: frame energy, log unit, background
// tracking, configuration and the result register. Depends on sed_pkg and sed_divider.
module sed_datapath #(
  parameter int SAMPLES_PER_FRAME = 256,
  parameter int BACKGROUND_FRAMES = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sed_pkg::dp_cmd_t                   cmd,
  output sed_pkg::dp_status_t                st,
  input  logic signed [sed_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                               first_sample,
  input  logic                               last_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               onset_found,
  output logic [sed_pkg::INDEX_W-1:0]        onset_offset,
  input  logic                               cfg_valid,
  input  logic [sed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sed_pkg::CFG_DAT_W-1:0]      cfg_data
);

  localparam int SIF_W = $clog2(SAMPLES_PER_FRAME);
  localparam int LW    = sed_pkg::LEVEL_W;

  // Configuration registers.
  logic [7:0]  ignore_frames;
  logic [7:0]  run_threshold;
  logic [15:0] speech_margin_db;
  logic [15:0] adjust_rate;
  logic [7:0]  forget_factor;

  // Detection state.
  logic [sed_pkg::ENERGY_W-1:0] energy_acc;
  logic [SIF_W-1:0]             sample_in_frame;
  logic [sed_pkg::FRAMES_W-1:0] frame_count;
  logic [sed_pkg::BGSUM_W-1:0]  background_sum;
  logic [LW-1:0]                background_db;
  logic [LW-1:0]                smoothed_level;
  logic [sed_pkg::RUN_W-1:0]    speech_run;
  logic [sed_pkg::INDEX_W-1:0]  sample_index;
  logic                         detection_done;

  // Per-frame working registers.
  logic [sed_pkg::ENERGY_W-1:0] norm_e;
  logic [5:0]                   log_int;
  logic [31:0]                  log_x;
  logic [63:0]                  sq_prod;
  logic [15:0]                  log_frac;
  logic [3:0]                   sq_cnt;
  logic [39:0]                  db_prod;
  logic [LW-1:0]                cur;
  logic [31:0]                  adj_prod;
  logic                         cur_lower;
  logic [sed_pkg::INDEX_W-1:0]  frame_idx;
  logic                         frame_last;
  logic                         frame_skip;
  logic                         frame_bg;
  logic                         frame_first;

  // Values seen by an accepted item after a possible restart.
  logic                         done_b;
  logic [sed_pkg::ENERGY_W-1:0] acc_b;
  logic [SIF_W-1:0]             sif_b;
  logic [sed_pkg::FRAMES_W-1:0] fc_b;
  logic [sed_pkg::INDEX_W-1:0]  idx_b;
  logic [15:0]                  mag;
  logic [sed_pkg::ENERGY_W-1:0] acc_sum;
  logic                         frame_end;
  logic [sed_pkg::FRAMES_W-1:0] ig_ext;
  logic [sed_pkg::FRAMES_W-1:0] ig_bg;

  // Squaring step, dB rounding and onset offset.
  logic [32:0]                  sq_shift;
  logic [40:0]                  db_round;
  logic [LW-1:0]                sm_clamp;
  logic [sed_pkg::INDEX_W-1:0]  start_idx;
  logic [sed_pkg::INDEX_W-1:0]  back_len;
  logic [sed_pkg::INDEX_W-1:0]  offset_val;

  // Divider hookup.
  logic                           div_start;
  logic [sed_pkg::DIV_NUM_W-1:0]  div_num;
  logic [sed_pkg::DIV_DEN_W-1:0]  div_den;
  logic [sed_pkg::DIV_NUM_W-1:0]  div_quo;
  logic                           div_done;

  sed_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  // Restart view and accumulation of the offered item.
  always_comb begin
    done_b    = first_sample ? 1'b0 : detection_done;
    acc_b     = first_sample ? '0 : energy_acc;
    sif_b     = first_sample ? '0 : sample_in_frame;
    fc_b      = first_sample ? '0 : frame_count;
    idx_b     = first_sample ? '0 : sample_index;
    mag       = sample_value[15] ? 16'(~sample_value + 16'd1) : sample_value;
    acc_sum   = acc_b + sed_pkg::ENERGY_W'(mag * mag);
    frame_end = sif_b == SIF_W'(SAMPLES_PER_FRAME - 1);
    ig_ext    = sed_pkg::FRAMES_W'(ignore_frames);
    ig_bg     = ig_ext + sed_pkg::FRAMES_W'(BACKGROUND_FRAMES);
  end

  // Arithmetic of the log unit, the decision and the offset.
  always_comb begin
    sq_shift   = sq_prod[63:31];
    db_round   = {1'b0, db_prod} + 41'(1 << 23);
    sm_clamp   = (smoothed_level < background_db) ? background_db : smoothed_level;
    start_idx  = frame_idx + 24'd1 - sed_pkg::INDEX_W'(SAMPLES_PER_FRAME);
    back_len   = sed_pkg::INDEX_W'({16'd0, run_threshold} * sed_pkg::INDEX_W'(SAMPLES_PER_FRAME));
    if (frame_idx >= sed_pkg::INDEX_MAX) begin
      offset_val = sed_pkg::INDEX_MAX;
    end else if (start_idx >= back_len) begin
      offset_val = start_idx - back_len;
    end else begin
      offset_val = '0;
    end
  end

  // Divider operands.
  always_comb begin
    div_start = 1'b0;
    div_num   = sed_pkg::DIV_NUM_W'(background_sum);
    div_den   = sed_pkg::DIV_DEN_W'(BACKGROUND_FRAMES);
    if (cmd.op == sed_pkg::OP_BG_DIV_START) begin
      div_start = 1'b1;
    end else if (cmd.op == sed_pkg::OP_SM_START) begin
      div_start = 1'b1;
      div_num   = sed_pkg::DIV_NUM_W'(smoothed_level * forget_factor)
                  + sed_pkg::DIV_NUM_W'(cur);
      div_den   = sed_pkg::DIV_DEN_W'(forget_factor) + 9'd1;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_frames    <= 8'd10;
      run_threshold    <= 8'd10;
      speech_margin_db <= 16'd2560;
      adjust_rate      <= 16'd3277;
      forget_factor    <= 8'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        sed_pkg::REG_IGNORE_FRAMES:    ignore_frames    <= cfg_data[7:0];
        sed_pkg::REG_RUN_THRESHOLD:    run_threshold    <= cfg_data[7:0];
        sed_pkg::REG_SPEECH_MARGIN_DB: speech_margin_db <= cfg_data;
        sed_pkg::REG_ADJUST_RATE:      adjust_rate      <= cfg_data;
        sed_pkg::REG_FORGET_FACTOR:    forget_factor    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Detection state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_acc      <= '0;
      sample_in_frame <= '0;
      frame_count     <= '0;
      background_sum  <= '0;
      background_db   <= '0;
      smoothed_level  <= '0;
      speech_run      <= '0;
      sample_index    <= '0;
      detection_done  <= 1'b0;
      out_valid       <= 1'b0;
      sq_cnt          <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        sed_pkg::OP_ACCEPT: begin
          if (first_sample) begin
            background_sum <= '0;
            background_db  <= '0;
            smoothed_level <= '0;
            speech_run     <= '0;
            detection_done <= 1'b0;
            energy_acc      <= '0;
            sample_in_frame <= '0;
            frame_count     <= '0;
            sample_index    <= '0;
          end
          if (!done_b) begin
            sample_index <= (idx_b < sed_pkg::INDEX_MAX) ? idx_b + 24'd1 : idx_b;
            frame_idx    <= idx_b;
            frame_last   <= last_sample;
            if (frame_end) begin
              energy_acc      <= '0;
              sample_in_frame <= '0;
              frame_count     <= (fc_b != '1) ? fc_b + 1'b1 : fc_b;
              norm_e          <= acc_sum;
              log_int         <= 6'd39;
              sq_cnt          <= '0;
              log_frac        <= '0;
              frame_skip      <= fc_b < ig_ext;
              frame_bg        <= fc_b < ig_bg;
              frame_first     <= fc_b == ig_bg;
            end else begin
              energy_acc      <= acc_sum;
              sample_in_frame <= sif_b + 1'b1;
              frame_count     <= fc_b;
              if (last_sample) begin
                detection_done <= 1'b1;
                out_valid      <= 1'b1;
                onset_found    <= 1'b0;
                onset_offset   <= '0;
              end
            end
          end
        end
        sed_pkg::OP_NORM: begin
          norm_e  <= {norm_e[sed_pkg::ENERGY_W-2:0], 1'b0};
          log_int <= log_int - 6'd1;
        end
        sed_pkg::OP_CUR_ZERO: cur <= '0;
        sed_pkg::OP_SQ_MUL: begin
          if (sq_cnt == 4'd0 && log_frac == 16'd0) begin
            sq_prod <= norm_e[39:8] * norm_e[39:8];
            log_x   <= norm_e[39:8];
          end else begin
            sq_prod <= log_x * log_x;
          end
        end
        sed_pkg::OP_SQ_UPD: begin
          log_frac <= {log_frac[14:0], sq_shift[32]};
          log_x    <= sq_shift[32] ? sq_shift[32:1] : sq_shift[31:0];
          sq_cnt   <= sq_cnt + 4'd1;
        end
        sed_pkg::OP_DB_MUL: db_prod <= 40'({log_int, log_frac} * sed_pkg::DB_PER_LOG2_Q16);
        sed_pkg::OP_DB_FIN: cur <= db_round[39:24];
        sed_pkg::OP_BG_ADD: background_sum <= background_sum + sed_pkg::BGSUM_W'(cur);
        sed_pkg::OP_BG_LOAD: background_db <= div_quo[LW-1:0];
        sed_pkg::OP_SM_LOAD: smoothed_level <= div_quo[LW-1:0];
        sed_pkg::OP_ADJ_MUL: begin
          cur_lower <= cur < background_db;
          adj_prod  <= (cur - background_db) * adjust_rate;
        end
        sed_pkg::OP_ADJ_ADD: begin
          if (cur_lower) begin
            background_db <= cur;
          end else begin
            background_db <= background_db + adj_prod[31:16];
          end
        end
        sed_pkg::OP_DECIDE: begin
          smoothed_level <= sm_clamp;
          if ((sm_clamp - background_db) > speech_margin_db) begin
            if (speech_run != '1) begin
              speech_run <= speech_run + 1'b1;
            end
          end else begin
            speech_run <= '0;
          end
        end
        sed_pkg::OP_EMIT_FOUND: begin
          detection_done <= 1'b1;
          out_valid      <= 1'b1;
          onset_found    <= 1'b1;
          onset_offset   <= offset_val;
        end
        sed_pkg::OP_EMIT_NONE: begin
          detection_done <= 1'b1;
          out_valid      <= 1'b1;
          onset_found    <= 1'b0;
          onset_offset   <= '0;
        end
        default: ;
      endcase
    end
  end

  // Status towards the controller.
  always_comb begin
    st.acc_frame_end = !done_b && frame_end;
    st.zero_energy   = norm_e == '0;
    st.norm_done     = norm_e[sed_pkg::ENERGY_W-1];
    st.sq_last       = sq_cnt == 4'd15;
    st.skip          = frame_skip;
    st.bg_phase      = frame_bg;
    st.first_class   = frame_first;
    st.div_done      = div_done;
    st.onset         = speech_run > run_threshold;
    st.last          = frame_last;
    st.out_valid     = out_valid;
  end

endmodule

FILE: hw/rtl/sed_controller.sv
// Controller of the speech endpoint detector: sequences the per-frame work of the
// datapath. Depends on sed_pkg.
module sed_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sed_pkg::dp_status_t st,
  output sed_pkg::dp_cmd_t    cmd
);

  sed_pkg::state_t state;
  sed_pkg::state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sed_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath operation.
  always_comb begin
    state_next = state;
    cmd.op     = sed_pkg::OP_NONE;
    in_ready   = (state == sed_pkg::S_IDLE) && !st.out_valid;
    unique case (state)
      sed_pkg::S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.op = sed_pkg::OP_ACCEPT;
          if (st.acc_frame_end) begin
            state_next = sed_pkg::S_NORM;
          end
        end
      end
      sed_pkg::S_NORM: begin
        if (st.zero_energy) begin
          cmd.op     = sed_pkg::OP_CUR_ZERO;
          state_next = sed_pkg::S_DISPATCH;
        end else if (st.norm_done) begin
          state_next = sed_pkg::S_SQ_MUL;
        end else begin
          cmd.op = sed_pkg::OP_NORM;
        end
      end
      sed_pkg::S_SQ_MUL: begin
        cmd.op     = sed_pkg::OP_SQ_MUL;
        state_next = sed_pkg::S_SQ_UPD;
      end
      sed_pkg::S_SQ_UPD: begin
        cmd.op     = sed_pkg::OP_SQ_UPD;
        state_next = st.sq_last ? sed_pkg::S_DB_MUL : sed_pkg::S_SQ_MUL;
      end
      sed_pkg::S_DB_MUL: begin
        cmd.op     = sed_pkg::OP_DB_MUL;
        state_next = sed_pkg::S_DB_FIN;
      end
      sed_pkg::S_DB_FIN: begin
        cmd.op     = sed_pkg::OP_DB_FIN;
        state_next = sed_pkg::S_DISPATCH;
      end
      sed_pkg::S_DISPATCH: begin
        if (st.skip) begin
          state_next = sed_pkg::S_FINISH;
        end else if (st.bg_phase) begin
          cmd.op     = sed_pkg::OP_BG_ADD;
          state_next = sed_pkg::S_FINISH;
        end else if (st.first_class) begin
          cmd.op     = sed_pkg::OP_BG_DIV_START;
          state_next = sed_pkg::S_BG_DIV;
        end else begin
          state_next = sed_pkg::S_SM_START;
        end
      end
      sed_pkg::S_BG_DIV: begin
        if (st.div_done) begin
          cmd.op     = sed_pkg::OP_BG_LOAD;
          state_next = sed_pkg::S_SM_START;
        end
      end
      sed_pkg::S_SM_START: begin
        cmd.op     = sed_pkg::OP_SM_START;
        state_next = sed_pkg::S_SM_DIV;
      end
      sed_pkg::S_SM_DIV: begin
        if (st.div_done) begin
          cmd.op     = sed_pkg::OP_SM_LOAD;
          state_next = sed_pkg::S_ADJ_MUL;
        end
      end
      sed_pkg::S_ADJ_MUL: begin
        cmd.op     = sed_pkg::OP_ADJ_MUL;
        state_next = sed_pkg::S_ADJ_ADD;
      end
      sed_pkg::S_ADJ_ADD: begin
        cmd.op     = sed_pkg::OP_ADJ_ADD;
        state_next = sed_pkg::S_DECIDE;
      end
      sed_pkg::S_DECIDE: begin
        cmd.op     = sed_pkg::OP_DECIDE;
        state_next = sed_pkg::S_CHECK;
      end
      sed_pkg::S_CHECK: begin
        if (st.onset) begin
          cmd.op     = sed_pkg::OP_EMIT_FOUND;
          state_next = sed_pkg::S_IDLE;
        end else begin
          state_next = sed_pkg::S_FINISH;
        end
      end
      sed_pkg::S_FINISH: begin
        if (st.last) begin
          cmd.op = sed_pkg::OP_EMIT_NONE;
        end
        state_next = sed_pkg::S_IDLE;
      end
      default: state_next = sed_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/speech_endpoint_detector.sv
// Speech endpoint detector. Takes one audio sample per cycle inside a frame; the
// sample that completes a frame holds the input while the frame is turned into a
// level: a one-bit-per-cycle normalising shift, sixteen squaring steps of the
// 32x32 multiplier, and up to two passes of the shared restoring divider. A
// result is offered on its own channel and no further sample is taken until it
// is collected. Depends on sed_pkg, sed_ifs, sed_controller and sed_datapath.
module speech_endpoint_detector #(
  parameter int SAMPLES_PER_FRAME = 256,
  parameter int BACKGROUND_FRAMES = 10
) (
  input  logic             clk,
  input  logic             rst,
  sed_sample_if.sink       sample_in,
  sed_onset_if.source      onset_out,
  sed_cfg_if.sink          cfg
);

  sed_pkg::dp_cmd_t    cmd;
  sed_pkg::dp_status_t st;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  sed_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(sample_in.valid),
    .in_ready(sample_in.ready),
    .st      (st),
    .cmd     (cmd)
  );

  sed_datapath #(
    .SAMPLES_PER_FRAME(SAMPLES_PER_FRAME),
    .BACKGROUND_FRAMES(BACKGROUND_FRAMES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .sample_value(sample_in.sample_value),
    .first_sample(sample_in.first_sample),
    .last_sample (sample_in.last_sample),
    .out_valid   (onset_out.valid),
    .out_ready   (onset_out.ready),
    .onset_found (onset_out.onset_found),
    .onset_offset(onset_out.onset_offset),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data)
  );

endmodule
